FILE: rtl/scpr_pkg.sv
`timescale 1ns / 1ps

package scpr_pkg;

   // Fixed port widths of the block
   localparam int CFG_W       = 5;
   localparam int PAGE_OUT_W  = 16;
   localparam int FRAME_OUT_W = 4;
   localparam int COUNT_W     = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 2;

   // Register map (byte addresses)
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAMES_ADDR = 2'd0;

   // Reset value of frames_in_use
   localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd4;

   // Engine state, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOOK  = 5'b00010,
      ST_SWEEP = 5'b00100,
      ST_EVRD  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

FILE: rtl/second_chance_page_replacement.sv
`timescale 1ns / 1ps

// Second-chance (clock) page replacement engine.
//
// Request channel (req_*): one page reference per transaction. The block takes
// one reference at a time; req_stall stays high from acceptance until the
// engine has handed its result to the output register.
// Response channel (rsp_*): exactly one result per reference: hit or fault,
// the frame holding the page, the evicted page if any, and saturating hit and
// fault totals. A result waits in the output register while rsp_stall is high,
// and the engine may work on the next reference meanwhile.
// CSR port (csr_*): APB-style, frames_in_use at byte address 0. Write only
// while the block is idle.
// Lookup: page numbers live in a synchronous memory with one write port and
// one registered read port, so the lookup reads one frame per cycle. A hit
// ends the lookup at the matching frame; a fault scans every active frame and
// takes a free frame if one is left, else the hand sweeps for a victim. The
// next reference can be taken in the cycle after the handover.
// Reset: synchronous. Clears valid and reference bits, hand, fill count,
// totals and frames_in_use (back to 4) at once; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register; a second
// finished result waits in the engine until the first is taken.
module second_chance_page_replacement #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [scpr_pkg::PAGE_OUT_W-1:0]       req_page_number,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic [scpr_pkg::FRAME_OUT_W-1:0]      rsp_frame_index,
   output logic                                  rsp_evicted_valid,
   output logic [scpr_pkg::PAGE_OUT_W-1:0]       rsp_evicted_page,
   output logic [scpr_pkg::COUNT_W-1:0]          rsp_hit_total,
   output logic [scpr_pkg::COUNT_W-1:0]          rsp_fault_total,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [scpr_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [scpr_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [scpr_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int IW = $clog2(MAX_FRAMES);       // frame index width
   localparam int CW = $clog2(MAX_FRAMES + 1);   // frame count width

   // Advance a frame index around the active ring
   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] h,
                                              input logic [CW-1:0] c);
      logic [CW:0] s;
      s = (CW + 1)'(h) + (CW + 1)'(1);
      return (s < (CW + 1)'(c)) ? IW'(s) : '0;
   endfunction

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   scpr_pkg::state_type               state_ff, state_in;
   logic [scpr_pkg::CFG_W-1:0]        cfg_frames_ff, cfg_frames_in;
   logic [PAGE_BITS-1:0]              page_ff, page_in;
   logic [CW-1:0]                     cap_ff, cap_in;
   logic [IW-1:0]                     addr_ff, addr_in;
   logic [IW-1:0]                     sweep_ff, sweep_in;
   logic [IW-1:0]                     hand_ff, hand_in;
   logic [CW-1:0]                     filled_ff, filled_in;
   logic [MAX_FRAMES-1:0]             valid_ff, valid_in;
   logic [MAX_FRAMES-1:0]             refb_ff, refb_in;
   logic [scpr_pkg::COUNT_W-1:0]      hit_cnt_ff, hit_cnt_in;
   logic [scpr_pkg::COUNT_W-1:0]      flt_cnt_ff, flt_cnt_in;

   // result being built by the engine
   logic                              res_hit_ff, res_hit_in;
   logic [IW-1:0]                     res_frame_ff, res_frame_in;
   logic                              res_evv_ff, res_evv_in;
   logic [PAGE_BITS-1:0]              res_evp_ff, res_evp_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_hit_ff;
   logic [scpr_pkg::FRAME_OUT_W-1:0]  rsp_frame_ff;
   logic                              rsp_evv_ff;
   logic [scpr_pkg::PAGE_OUT_W-1:0]   rsp_evp_ff;
   logic [scpr_pkg::COUNT_W-1:0]      rsp_hit_tot_ff;
   logic [scpr_pkg::COUNT_W-1:0]      rsp_flt_tot_ff;

   // page memory
   logic [PAGE_BITS-1:0]              page_mem [MAX_FRAMES];
   logic [PAGE_BITS-1:0]              rd_data_ff;
   logic [IW-1:0]                     rd_addr;
   logic                              mem_we;

   logic [CW-1:0]                     active_cap;
   logic                              req_take;
   logic                              finish;
   logic                              match;
   logic                              last_frame;
   logic                              csr_write;

   // ---------------------------------------------------------------------
   // CSR port
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == scpr_pkg::CSR_FRAMES_ADDR);

   always_comb begin
      cfg_frames_in = cfg_frames_ff;
      if (csr_write) begin
         cfg_frames_in = csr_pwdata[scpr_pkg::CFG_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == scpr_pkg::CSR_FRAMES_ADDR) begin
         csr_prdata = scpr_pkg::CSR_DATA_W'(cfg_frames_ff);
      end
   end

   // Clamp frames_in_use into 1..MAX_FRAMES
   always_comb begin
      if (cfg_frames_ff == '0) begin
         active_cap = CW'(1);
      end else if (32'(cfg_frames_ff) > 32'(MAX_FRAMES)) begin
         active_cap = CW'(MAX_FRAMES);
      end else begin
         active_cap = CW'(cfg_frames_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != scpr_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // Hand the result over when the output register is empty or draining
   assign finish = (state_ff == scpr_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Data in rd_data_ff belongs to frame addr_ff during lookup
   assign match      = valid_ff[addr_ff] && (rd_data_ff == page_ff);
   assign last_frame = ((CW + 1)'(addr_ff) + (CW + 1)'(1)) == (CW + 1)'(cap_ff);

   // ---------------------------------------------------------------------
   // Engine
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      cap_in       = cap_ff;
      addr_in      = addr_ff;
      sweep_in     = sweep_ff;
      hand_in      = hand_ff;
      filled_in    = filled_ff;
      valid_in     = valid_ff;
      refb_in      = refb_ff;
      hit_cnt_in   = hit_cnt_ff;
      flt_cnt_in   = flt_cnt_ff;
      res_hit_in   = res_hit_ff;
      res_frame_in = res_frame_ff;
      res_evv_in   = res_evv_ff;
      res_evp_in   = res_evp_ff;
      rd_addr      = '0;
      mem_we       = 1'b0;

      case (state_ff)
         scpr_pkg::ST_IDLE: begin
            // Issue the read of frame 0 with the acceptance edge
            rd_addr = '0;
            if (req_take) begin
               page_in  = PAGE_BITS'(req_page_number);
               cap_in   = active_cap;
               addr_in  = '0;
               state_in = scpr_pkg::ST_LOOK;
            end
         end

         scpr_pkg::ST_LOOK: begin
            rd_addr = addr_ff + IW'(1);
            if (match) begin
               res_hit_in   = 1'b1;
               res_frame_in = addr_ff;
               res_evv_in   = 1'b0;
               res_evp_in   = '0;
               state_in     = scpr_pkg::ST_DONE;
            end else if (last_frame) begin
               res_hit_in = 1'b0;
               res_evv_in = 1'b0;
               res_evp_in = '0;
               if (filled_ff < cap_ff) begin
                  // free frame left: fill in order
                  res_frame_in = IW'(filled_ff);
                  filled_in    = filled_ff + CW'(1);
                  state_in     = scpr_pkg::ST_DONE;
               end else begin
                  // restart the hand if the ring shrank under it
                  sweep_in = (CW'(hand_ff) < cap_ff) ? hand_ff : '0;
                  state_in = scpr_pkg::ST_SWEEP;
               end
            end else begin
               addr_in = addr_ff + IW'(1);
            end
         end

         scpr_pkg::ST_SWEEP: begin
            // Keep reading the frame under the hand for the victim's page
            rd_addr = sweep_ff;
            if (refb_ff[sweep_ff]) begin
               refb_in[sweep_ff] = 1'b0;
               sweep_in          = wrap_inc(sweep_ff, cap_ff);
            end else begin
               state_in = scpr_pkg::ST_EVRD;
            end
         end

         scpr_pkg::ST_EVRD: begin
            rd_addr      = sweep_ff;
            res_frame_in = sweep_ff;
            res_evv_in   = valid_ff[sweep_ff];
            res_evp_in   = valid_ff[sweep_ff] ? rd_data_ff : '0;
            hand_in      = wrap_inc(sweep_ff, cap_ff);
            state_in     = scpr_pkg::ST_DONE;
         end

         scpr_pkg::ST_DONE: begin
            if (finish) begin
               state_in = scpr_pkg::ST_IDLE;
               if (res_hit_ff) begin
                  refb_in[res_frame_ff] = 1'b1;
                  hit_cnt_in = (hit_cnt_ff == '1) ? hit_cnt_ff
                                                  : hit_cnt_ff + scpr_pkg::COUNT_W'(1);
               end else begin
                  refb_in[res_frame_ff]  = 1'b0;
                  valid_in[res_frame_ff] = 1'b1;
                  mem_we                 = 1'b1;
                  flt_cnt_in = (flt_cnt_ff == '1) ? flt_cnt_ff
                                                  : flt_cnt_ff + scpr_pkg::COUNT_W'(1);
               end
            end
         end

         default: begin
            state_in = scpr_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register: hold while stalled, load on finish
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scpr_pkg::ST_IDLE;
         cfg_frames_ff <= scpr_pkg::FRAMES_RESET;
         hand_ff       <= '0;
         filled_ff     <= '0;
         valid_ff      <= '0;
         refb_ff       <= '0;
         hit_cnt_ff    <= '0;
         flt_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_frames_ff <= cfg_frames_in;
         hand_ff       <= hand_in;
         filled_ff     <= filled_in;
         valid_ff      <= valid_in;
         refb_ff       <= refb_in;
         hit_cnt_ff    <= hit_cnt_in;
         flt_cnt_ff    <= flt_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      cap_ff       <= cap_in;
      addr_ff      <= addr_in;
      sweep_ff     <= sweep_in;
      res_hit_ff   <= res_hit_in;
      res_frame_ff <= res_frame_in;
      res_evv_ff   <= res_evv_in;
      res_evp_ff   <= res_evp_in;
      if (finish) begin
         rsp_hit_ff     <= res_hit_ff;
         rsp_frame_ff   <= scpr_pkg::FRAME_OUT_W'(res_frame_ff);
         rsp_evv_ff     <= res_evv_ff;
         rsp_evp_ff     <= scpr_pkg::PAGE_OUT_W'(res_evp_ff);
         rsp_hit_tot_ff <= hit_cnt_in;
         rsp_flt_tot_ff <= flt_cnt_in;
      end
   end

   // Page memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[res_frame_ff] <= page_ff;
      end
      rd_data_ff <= page_mem[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_evv_ff;
   assign rsp_evicted_page  = rsp_evp_ff;
   assign rsp_hit_total     = rsp_hit_tot_ff;
   assign rsp_fault_total   = rsp_flt_tot_ff;

endmodule

FILE: rtl/scpr_checker.sv
`timescale 1ns / 1ps

module scpr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_hit,
   input logic [scpr_pkg::FRAME_OUT_W-1:0]  rsp_frame_index,
   input logic                              rsp_evicted_valid,
   input logic [scpr_pkg::PAGE_OUT_W-1:0]   rsp_evicted_page,
   input logic [scpr_pkg::COUNT_W-1:0]      rsp_hit_total,
   input logic [scpr_pkg::COUNT_W-1:0]      rsp_fault_total
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_frame_index) && $stable(rsp_evicted_page) &&
      $stable(rsp_hit_total) && $stable(rsp_fault_total))
      else $error("stalled result changed");

   // A hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evicted_valid && (rsp_evicted_page == '0))
      else $error("hit reported an eviction");

   // No eviction means a zero page
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> (rsp_evicted_page == '0))
      else $error("evicted page nonzero without eviction");

   // One reference at a time: stall right after a transaction
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // Output empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind second_chance_page_replacement scpr_checker u_scpr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_hit           (rsp_hit),
   .rsp_frame_index   (rsp_frame_index),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_page  (rsp_evicted_page),
   .rsp_hit_total     (rsp_hit_total),
   .rsp_fault_total   (rsp_fault_total)
);
